// ===== hw/rtl/rgb_to_hsv_converter_macros.svh =====
// Assertion macros used by the checker of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Checked on every clock edge outside reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define RHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/rhc_pkg.sv =====
// Shared widths, stage counts and types of the RGB to HSV converter.
package rhc_pkg;

  localparam int ChanW        = 8;
  localparam int PosW         = 11;
  localparam int NumW         = 19;
  localparam int DenW         = 11;
  localparam int QuoW         = 8;
  localparam int BitsPerStage = 2;
  localparam int DivStages    = QuoW / BitsPerStage;
  localparam int FrontStages  = 3;
  localparam int NumStages    = FrontStages + DivStages;

  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [1:0] {
    MaxRed,
    MaxGreen,
    MaxBlue
  } max_sel_e;

endpackage

// ===== hw/rtl/rhc_div.sv =====
// Pipelined restoring divider that retires two quotient bits per stage.
module rhc_div (
  input  logic                           clk_i,
  input  logic [rhc_pkg::DivStages-1:0]  en_i,
  input  logic [rhc_pkg::NumW-1:0]       num_i,
  input  logic [rhc_pkg::DenW-1:0]       den_i,
  output logic [rhc_pkg::QuoW-1:0]       quo_o
);
  import rhc_pkg::*;

  logic [NumW-1:0] rem_q [DivStages-1];
  logic [DenW-1:0] den_q [DivStages-1];
  logic [QuoW-1:0] quo_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [NumW-1:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < BitsPerStage; j++) begin
        trial = NumW'(den_in) << (QuoW - 1 - k * BitsPerStage - j);
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          quo_d = {quo_d[QuoW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= quo_d;
      end
    end

    if (k < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// Converts 8-bit RGBA pixels to 8-bit HSV with alpha passed through. The block
// takes one pixel per clock cycle when the output is not stalled. Three front
// stages find the maximum, the minimum and the hue position and form the
// dividends and divisors; four divider stages then retire two quotient bits
// each for saturation and hue. A stall at the output holds only the stages that
// are full, so bubbles close up and every stage holds a pixel before the input
// stalls.
module rgb_to_hsv_converter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  rhc_pkg::chan_t       red_i,
  input  rhc_pkg::chan_t       green_i,
  input  rhc_pkg::chan_t       blue_i,
  input  rhc_pkg::chan_t       alpha_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output rhc_pkg::chan_t       hue_o,
  output rhc_pkg::chan_t       saturation_o,
  output rhc_pkg::chan_t       brightness_o,
  output rhc_pkg::chan_t       alpha_out_o
);
  import rhc_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  chan_t    mx_q    [NumStages];
  chan_t    alpha_q [NumStages];
  chan_t    mx_d;

  chan_t    r_q, g_q, b_q, mn_q, mn_d;
  max_sel_e sel_q, sel_d;

  chan_t           delta_q, delta_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic [NumW-1:0] num_s_q, num_s_d, num_h_q, num_h_d;
  logic [DenW-1:0] den_s_q, den_s_d, den_h_q, den_h_d;

  assign en[NumStages-1] = !valid_q[NumStages-1] || !stall_i;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  assign valid_d = {valid_q[NumStages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (en & valid_d) | (~en & valid_q);
    end
  end

  assign stall_o = !en[0];

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sel_d = MaxRed;
      mx_d  = red_i;
    end else if (green_i >= blue_i) begin
      sel_d = MaxGreen;
      mx_d  = green_i;
    end else begin
      sel_d = MaxBlue;
      mx_d  = blue_i;
    end
    if (red_i <= green_i && red_i <= blue_i) begin
      mn_d = red_i;
    end else if (green_i <= blue_i) begin
      mn_d = green_i;
    end else begin
      mn_d = blue_i;
    end
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          mx_q[k]    <= mx_d;
          alpha_q[k] <= alpha_i;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          mx_q[k]    <= mx_q[k-1];
          alpha_q[k] <= alpha_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q   <= red_i;
      g_q   <= green_i;
      b_q   <= blue_i;
      mn_q  <= mn_d;
      sel_q <= sel_d;
    end
  end

  // The hue position is k*delta + d; modular arithmetic keeps it exact.
  always_comb begin
    delta_d = mx_q[0] - mn_q;
    case (sel_q)
      MaxRed: begin
        if (g_q >= b_q) begin
          pos_d = PosW'(g_q) - PosW'(b_q);
        end else begin
          pos_d = (PosW'(delta_d) << 2) + (PosW'(delta_d) << 1)
                  + PosW'(g_q) - PosW'(b_q);
        end
      end
      MaxGreen: pos_d = (PosW'(delta_d) << 1) + PosW'(b_q) - PosW'(r_q);
      MaxBlue:  pos_d = (PosW'(delta_d) << 2) + PosW'(r_q) - PosW'(g_q);
      default:  pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      delta_q <= delta_d;
      pos_q   <= pos_d;
    end
  end

  // A zero divisor only comes with a zero dividend, so it is replaced by one.
  always_comb begin
    num_s_d = (NumW'(delta_q) << ChanW) - NumW'(delta_q);
    num_h_d = (NumW'(pos_q) << ChanW) - NumW'(pos_q);
    den_s_d = (mx_q[1] == '0) ? DenW'(1) : DenW'(mx_q[1]);
    den_h_d = (delta_q == '0) ? DenW'(1)
                              : (DenW'(delta_q) << 2) + (DenW'(delta_q) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      num_s_q <= num_s_d;
      num_h_q <= num_h_d;
      den_s_q <= den_s_d;
      den_h_q <= den_h_d;
    end
  end

  rhc_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:FrontStages]),
    .num_i (num_s_q),
    .den_i (den_s_q),
    .quo_o (saturation_o)
  );

  rhc_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:FrontStages]),
    .num_i (num_h_q),
    .den_i (den_h_q),
    .quo_o (hue_o)
  );

  assign valid_o      = valid_q[NumStages-1];
  assign brightness_o = mx_q[NumStages-1];
  assign alpha_out_o  = alpha_q[NumStages-1];

endmodule

// ===== hw/rtl/rhc_checker.sv =====
// Port-level checker for the RGB to HSV converter and its bind statement.
module rhc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           valid_o,
  input logic           stall_i,
  input rhc_pkg::chan_t hue_o,
  input rhc_pkg::chan_t saturation_o,
  input rhc_pkg::chan_t brightness_o
);
  import rhc_pkg::*;

`include "rgb_to_hsv_converter_macros.svh"

  `RHC_ASSERT(a_hue_range, valid_o |-> hue_o != 8'hff, "Hue reached the full turn.")
  `RHC_ASSERT(a_grey_hue, (valid_o && saturation_o == '0) |-> hue_o == '0, "Grey pixel has hue.")
  `RHC_ASSERT(a_black_sat, (valid_o && brightness_o == '0) |-> saturation_o == '0, "Black has saturation.")
  `RHC_ASSERT(a_hold, (valid_o && stall_i) |=> (valid_o && $stable(hue_o) && $stable(saturation_o)), "Stalled request changed.")
  `RHC_ASSERT_ALWAYS(a_reset, !rst_ni |=> !valid_o, "Request shown right after reset.")

endmodule

bind rgb_to_hsv_converter rhc_checker u_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RGB to HSV converter with random idling on both sides.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t brightness;
    chan_t alpha;
  } hsv_pixel_t;

  typedef enum {IdleOff, IdleLight, IdleHeavy} idle_mode_e;

  class hsv_scoreboard;
    hsv_pixel_t pending_q[$];
    int unsigned errors = 0;
    int unsigned requests = 0;
    int unsigned results = 0;

    function hsv_pixel_t convert(chan_t r, chan_t g, chan_t b, chan_t a);
      hsv_pixel_t px;
      max_sel_e   sel;
      int         mx;
      int         mn;
      int         delta;
      int         pos;
      if (r >= g && r >= b) begin
        sel = MaxRed;
        mx  = r;
      end else if (g >= b) begin
        sel = MaxGreen;
        mx  = g;
      end else begin
        sel = MaxBlue;
        mx  = b;
      end
      mn = (r < g) ? r : g;
      mn = (b < mn) ? b : mn;
      delta = mx - mn;
      px.brightness = chan_t'(mx);
      px.alpha = a;
      px.saturation = (mx == 0) ? '0 : chan_t'((255 * delta) / mx);
      if (delta == 0) begin
        px.hue = '0;
      end else begin
        case (sel)
          MaxRed:   pos = (g >= b) ? (g - b) : (6 * delta - (b - g));
          MaxGreen: pos = 2 * delta + b - r;
          default:  pos = 4 * delta + r - g;
        endcase
        px.hue = chan_t'((255 * pos) / (6 * delta));
      end
      return px;
    endfunction

    function void note_request(chan_t r, chan_t g, chan_t b, chan_t a);
      pending_q.push_back(convert(r, g, b, a));
      requests++;
    endfunction

    function void check_result(hsv_pixel_t got);
      hsv_pixel_t want;
      results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: hue %0d saturation %0d brightness %0d alpha %0d",
               got.hue, got.saturation, got.brightness, got.alpha);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, actual %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
        errors++;
      end
      if (got.brightness !== want.brightness) begin
        $error("brightness: expected %0d, actual %0d", want.brightness, got.brightness);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha_out: expected %0d, actual %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction
  endclass

  localparam int NumDirected = 21;
  localparam int PhaseItems  = 280;

  localparam logic [31:0] DIRECTED [NumDirected] = '{
    32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'h80_80_80_5A, 32'hFF_00_00_AA,
    32'h00_FF_00_55, 32'h00_00_FF_00, 32'hFF_FF_00_FF, 32'h00_FF_FF_01,
    32'hFF_00_FF_80, 32'hFF_00_01_7F, 32'hFF_01_00_FE, 32'h0A_C8_64_33,
    32'h64_0A_C8_CC, 32'h01_00_00_00, 32'h00_00_01_FF, 32'hFF_FE_FE_11,
    32'hFE_FF_FF_EE, 32'h00_01_01_22, 32'h01_01_00_DD, 32'h01_01_01_44,
    32'h7F_80_7F_BB
  };

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  valid_i = 1'b0;
  logic  stall_i = 1'b0;
  chan_t red_i = '0;
  chan_t green_i = '0;
  chan_t blue_i = '0;
  chan_t alpha_i = '0;
  logic  stall_o;
  logic  valid_o;
  chan_t hue_o;
  chan_t saturation_o;
  chan_t brightness_o;
  chan_t alpha_out_o;

  hsv_scoreboard hsv_sb = new();
  idle_mode_e    send_mode = IdleLight;
  idle_mode_e    recv_mode = IdleLight;
  int            stall_left = 0;

  rgb_to_hsv_converter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o),
    .alpha_out_o  (alpha_out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int draw_wait(idle_mode_e mode);
    case (mode)
      IdleOff:   return 0;
      IdleLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default:   return $urandom_range(0, 16);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      hsv_sb.check_result(hsv_pixel_t'{hue_o, saturation_o, brightness_o, alpha_out_o});
      stall_left = draw_wait(recv_mode);
    end
    if (stall_left > 0) begin
      stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_i <= 1'b0;
    end
  end

  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b, input chan_t a);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    alpha_i <= a;
    do @(posedge clk_i); while (stall_o);
    hsv_sb.note_request(r, g, b, a);
  endtask

  // Mixes fully random pixels with greys, ties for the maximum and near ties for it.
  task automatic send_random_pixel();
    chan_t hi;
    chan_t lo;
    chan_t third;
    int    kind;
    kind  = $urandom_range(0, 9);
    hi    = chan_t'($urandom_range(0, 255));
    lo    = chan_t'($urandom_range(0, hi));
    third = chan_t'($urandom_range(lo, hi));
    case (kind)
      0: send_pixel(hi, hi, hi, chan_t'($urandom));
      1: send_pixel(hi, hi, lo, chan_t'($urandom));
      2: send_pixel(lo, hi, hi, chan_t'($urandom));
      3: send_pixel(hi, lo, hi, chan_t'($urandom));
      4: begin
        lo = (hi == 0) ? hi : chan_t'(hi - $urandom_range(1, (hi < 3) ? hi : 3));
        case ($urandom_range(0, 2))
          0:       send_pixel(hi, lo, third, chan_t'($urandom));
          1:       send_pixel(third, hi, lo, chan_t'($urandom));
          default: send_pixel(lo, third, hi, chan_t'($urandom));
        endcase
      end
      default: send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
                          chan_t'($urandom));
    endcase
  endtask

  task automatic wait_for_results();
    valid_i <= 1'b0;
    while (hsv_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    idle_mode_e send_plan [5] = '{IdleOff, IdleHeavy, IdleOff, IdleHeavy, IdleLight};
    idle_mode_e recv_plan [5] = '{IdleOff, IdleOff, IdleHeavy, IdleHeavy, IdleLight};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i]) begin
      send_pixel(DIRECTED[i][31:24], DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);
    end
    wait_for_results();
    for (int phase = 0; phase < 5; phase++) begin
      send_mode = send_plan[phase];
      recv_mode = recv_plan[phase];
      repeat (PhaseItems) send_random_pixel();
      if (phase == 2) wait_for_results();
    end
    wait_for_results();
    repeat (20) @(posedge clk_i);
    $display("Converted %0d pixels (%0d directed, rest random incl. greys and ties),",
             hsv_sb.requests, NumDirected);
    $display("checked %0d results under idle and stall phases.", hsv_sb.results);
    if (hsv_sb.errors == 0 && hsv_sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
